// ===== src/tpsls_pkg.sv =====
// Shared types, constants and the task ordering compare for the
// two-processor load scheduler. No dependencies.
`timescale 1ns / 1ps
package tpsls_pkg;

    localparam int DEF_MAX_TASKS = 16;
    localparam int DEF_TIME_BITS = 16;
    localparam int IN_TIME_W     = 16;
    localparam int OUT_TIME_W    = 22;
    localparam int OUT_NUM_W     = 5;

    // previous processor codes
    localparam logic [1:0] PREV_NONE = 2'd0;
    localparam logic [1:0] PREV_P1   = 2'd1;
    localparam logic [1:0] PREV_P2   = 2'd2;

    typedef struct packed {
        logic                 processor;
        logic [IN_TIME_W-1:0] load_time;
        logic [IN_TIME_W-1:0] run_time;
        logic                 last_task;
    } t_task;

    typedef struct packed {
        logic                  sched_processor;
        logic [OUT_NUM_W-1:0]  task_number;
        logic [OUT_TIME_W-1:0] finish_time;
        logic [OUT_TIME_W-1:0] makespan;
        logic                  overflow;
        logic                  last_result;
    } t_result;

    // true when task a strictly precedes task b on run, then load
    function automatic logic goes_before(logic [31:0] a_run, logic [31:0] a_load,
                                         logic [31:0] b_run, logic [31:0] b_load);
        goes_before = (a_run > b_run) || ((a_run == b_run) && (a_load > b_load));
    endfunction

endpackage

// ===== src/two_processor_server_load_scheduler_top.sv =====
// Top level of the two-processor load scheduler: control sequencer,
// per-processor task RAMs and result register. Uses tpsls_pkg,
// tpsls_ram and tpsls_pick.
//
//  channel | ports                     | transfer
//  --------+---------------------------+----------------------------------
//  task in | start, busy, i_task       | edge with start high, busy low
//  result  | o_valid, o_result         | each cycle with o_valid high
//
// Insertion: a task is inserted into its processor's sorted RAM by walking
// down from the tail, one read-compare-shift per cycle. A task into an
// empty list is written, and a task for a full list is dropped, at the
// accepting edge with no walk. After the last task the schedule drains one
// result at a time: head read (S_SRD), then pick (S_SCALC). Reset clears
// state, counts, indices, times and flags only; RAM contents are only used
// below the counts. Results cannot be held off; busy stays high until the
// final result is issued.
`timescale 1ns / 1ps
module two_processor_server_load_scheduler_top #(
    parameter int MAX_TASKS = tpsls_pkg::DEF_MAX_TASKS,
    parameter int TIME_BITS = tpsls_pkg::DEF_TIME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tpsls_pkg::t_task   i_task,
    output logic               o_valid,
    output tpsls_pkg::t_result o_result
);
    localparam int TB = TIME_BITS;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int AW = $clog2(MAX_TASKS);
    localparam int NW = CW;
    localparam int EW = NW + 2 * TB;
    localparam int TW = TB + $clog2(MAX_TASKS) + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SCALC = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [TB-1:0] r_kload, n_kload, r_krun, n_krun;
    logic          r_proc, n_proc, r_last, n_last;
    logic [CW-1:0] r_j, n_j, r_cnt1, n_cnt1, r_cnt2, n_cnt2, r_i1, n_i1, r_i2, n_i2;
    logic [TW-1:0] r_loader, n_loader, r_free1, n_free1, r_free2, n_free2;
    logic [TW-1:0] r_long, n_long;
    logic [1:0]    r_prev, n_prev;
    logic          r_drop, n_drop;
    logic          r_valid, n_valid;
    tpsls_pkg::t_result r_out, n_out;

    logic          we, wproc;
    logic [AW-1:0] waddr, raddr_c, raddr1, raddr2;
    logic [EW-1:0] wdata, rd1, rd2, rd_s;
    logic [CW-1:0] in_cnt, cur_cnt;
    logic [NW-1:0] key_num;
    logic [EW-1:0] key;
    logic          sel;
    logic [NW-1:0] p_num;
    logic [TW-1:0] p_loader, p_fin, fin_max;
    logic          final_pick;

    tpsls_ram #(.W(EW), .D(MAX_TASKS)) u_ram1 (
        .i_clk(i_clk), .i_we(we && !wproc), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr1), .o_rdata(rd1)
    );
    tpsls_ram #(.W(EW), .D(MAX_TASKS)) u_ram2 (
        .i_clk(i_clk), .i_we(we && wproc), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr2), .o_rdata(rd2)
    );

    tpsls_pick #(.TB(TB), .TW(TW), .NW(NW)) u_pick (
        .i_e1(rd1), .i_e2(rd2), .i_has1(r_i1 < r_cnt1), .i_has2(r_i2 < r_cnt2),
        .i_prev(r_prev), .i_loader(r_loader), .i_free1(r_free1), .i_free2(r_free2),
        .o_sel(sel), .o_num(p_num), .o_loader(p_loader), .o_fin(p_fin)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    assign in_cnt  = i_task.processor ? r_cnt2 : r_cnt1;
    assign cur_cnt = r_proc ? r_cnt2 : r_cnt1;
    assign key_num = NW'(cur_cnt + CW'(1));
    assign key     = {key_num, r_krun, r_kload};
    assign rd_s    = r_proc ? rd2 : rd1;
    assign raddr1  = (r_state == S_SRD) ? r_i1[AW-1:0] : raddr_c;
    assign raddr2  = (r_state == S_SRD) ? r_i2[AW-1:0] : raddr_c;
    assign fin_max = (p_fin > r_long) ? p_fin : r_long;
    assign final_pick = ({1'b0, r_i1} + {1'b0, r_i2} + (CW+1)'(1))
                        == ({1'b0, r_cnt1} + {1'b0, r_cnt2});

    always_comb begin
        n_state = r_state;   n_kload = r_kload;   n_krun = r_krun;
        n_proc = r_proc;     n_last = r_last;     n_j = r_j;
        n_cnt1 = r_cnt1;     n_cnt2 = r_cnt2;     n_i1 = r_i1;   n_i2 = r_i2;
        n_loader = r_loader; n_free1 = r_free1;   n_free2 = r_free2;
        n_long = r_long;     n_prev = r_prev;     n_drop = r_drop;
        n_valid = 1'b0;      n_out = r_out;
        we = 1'b0;           wproc = r_proc;      waddr = r_j[AW-1:0];
        wdata = key;         raddr_c = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_proc  = i_task.processor;
                    n_last  = i_task.last_task;
                    n_kload = TB'(i_task.load_time);
                    n_krun  = TB'(i_task.run_time);
                    if (in_cnt == CW'(MAX_TASKS)) begin
                        // drop: store full
                        n_drop  = 1'b1;
                        n_state = i_task.last_task ? S_SRD : S_IDLE;
                    end else if (in_cnt == '0) begin
                        we    = 1'b1;
                        wproc = i_task.processor;
                        waddr = '0;
                        wdata = {NW'(1), TB'(i_task.run_time), TB'(i_task.load_time)};
                        if (i_task.processor) n_cnt2 = CW'(1);
                        else                  n_cnt1 = CW'(1);
                        n_state = i_task.last_task ? S_SRD : S_IDLE;
                    end else begin
                        n_j     = in_cnt;
                        raddr_c = AW'(in_cnt - CW'(1));
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (tpsls_pkg::goes_before(32'(r_krun), 32'(r_kload),
                                           32'(rd_s[2*TB-1:TB]), 32'(rd_s[TB-1:0]))) begin
                    // shift the entry up one slot and keep walking
                    we    = 1'b1;
                    wdata = rd_s;
                    n_j   = r_j - CW'(1);
                    if (r_j == CW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        raddr_c = AW'(r_j - CW'(2));
                    end
                end else begin
                    we = 1'b1;
                    if (r_proc) n_cnt2 = r_cnt2 + CW'(1);
                    else        n_cnt1 = r_cnt1 + CW'(1);
                    n_state = r_last ? S_SRD : S_IDLE;
                end
            end
            S_PUT: begin
                we = 1'b1;
                if (r_proc) n_cnt2 = r_cnt2 + CW'(1);
                else        n_cnt1 = r_cnt1 + CW'(1);
                n_state = r_last ? S_SRD : S_IDLE;
            end
            S_SRD: begin
                n_state = S_SCALC;
            end
            S_SCALC: begin
                n_valid = 1'b1;
                n_out.sched_processor = sel;
                n_out.task_number     = tpsls_pkg::OUT_NUM_W'(p_num);
                n_out.finish_time     = tpsls_pkg::OUT_TIME_W'(p_fin);
                n_out.makespan        = tpsls_pkg::OUT_TIME_W'(fin_max);
                n_out.overflow        = r_drop;
                n_out.last_result     = final_pick;
                n_loader = p_loader;
                n_long   = fin_max;
                if (sel) begin
                    n_free2 = p_fin;
                    n_i2    = r_i2 + CW'(1);
                    n_prev  = tpsls_pkg::PREV_P2;
                end else begin
                    n_free1 = p_fin;
                    n_i1    = r_i1 + CW'(1);
                    n_prev  = tpsls_pkg::PREV_P1;
                end
                if (final_pick) begin
                    // end of run: return to reset state
                    n_cnt1 = '0;  n_cnt2 = '0;  n_i1 = '0;  n_i2 = '0;
                    n_loader = '0; n_free1 = '0; n_free2 = '0; n_long = '0;
                    n_prev = tpsls_pkg::PREV_NONE;
                    n_drop = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt1 <= '0; r_cnt2 <= '0; r_i1 <= '0; r_i2 <= '0;
            r_loader <= '0; r_free1 <= '0; r_free2 <= '0; r_long <= '0;
            r_prev <= tpsls_pkg::PREV_NONE;
            r_drop <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt1 <= n_cnt1; r_cnt2 <= n_cnt2; r_i1 <= n_i1; r_i2 <= n_i2;
            r_loader <= n_loader; r_free1 <= n_free1; r_free2 <= n_free2;
            r_long <= n_long;
            r_prev <= n_prev;
            r_drop <= n_drop;
            r_valid <= n_valid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_kload <= n_kload;
        r_krun  <= n_krun;
        r_proc  <= n_proc;
        r_last  <= n_last;
        r_j     <= n_j;
        r_out   <= n_out;
    end
endmodule

// ===== src/tpsls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tpsls_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/tpsls_pick.sv =====
// Schedule step: choose the next processor from the two list heads and
// work out the load start and finish times. Uses tpsls_pkg.
`timescale 1ns / 1ps
module tpsls_pick #(
    parameter int TB = 16,
    parameter int TW = 23,
    parameter int NW = 5
) (
    input  logic [NW+2*TB-1:0] i_e1,
    input  logic [NW+2*TB-1:0] i_e2,
    input  logic               i_has1,
    input  logic               i_has2,
    input  logic [1:0]         i_prev,
    input  logic [TW-1:0]      i_loader,
    input  logic [TW-1:0]      i_free1,
    input  logic [TW-1:0]      i_free2,
    output logic               o_sel,
    output logic [NW-1:0]      o_num,
    output logic [TW-1:0]      o_loader,
    output logic [TW-1:0]      o_fin
);
    logic [TB-1:0]      load1, run1, load2, run2, load_s, run_s;
    logic [TW-1:0]      pfree, start;

    assign load1 = i_e1[TB-1:0];
    assign run1  = i_e1[2*TB-1:TB];
    assign load2 = i_e2[TB-1:0];
    assign run2  = i_e2[2*TB-1:TB];

    always_comb begin
        if (i_prev == tpsls_pkg::PREV_P1) begin
            o_sel = i_has2;
        end else if (i_prev == tpsls_pkg::PREV_P2) begin
            o_sel = !i_has1;
        end else if (i_has1 && i_has2) begin
            // processor 1 wins a full tie
            o_sel = tpsls_pkg::goes_before(32'(run2), 32'(load2), 32'(run1), 32'(load1));
        end else begin
            o_sel = !i_has1;
        end
    end

    assign load_s   = o_sel ? load2 : load1;
    assign run_s    = o_sel ? run2 : run1;
    assign o_num    = o_sel ? i_e2[NW+2*TB-1:2*TB] : i_e1[NW+2*TB-1:2*TB];
    assign pfree    = o_sel ? i_free2 : i_free1;
    assign start    = (i_loader > pfree) ? i_loader : pfree;
    assign o_loader = start + TW'(load_s);
    assign o_fin    = o_loader + TW'(run_s);
endmodule

// ===== tb/tb_two_processor_server_load_scheduler_top.sv =====
// Self-checking testbench for the two-processor load scheduler.
// Depends on tpsls_pkg and two_processor_server_load_scheduler_top.
`timescale 1ns / 1ps
module tb_two_processor_server_load_scheduler_top;

    localparam int MAX_T = tpsls_pkg::DEF_MAX_TASKS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    tpsls_pkg::t_task   i_task;
    logic               o_valid;
    tpsls_pkg::t_result o_result;

    two_processor_server_load_scheduler_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_task(i_task), .o_valid(o_valid), .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Shadow copy of the scheduler's state
    typedef struct {
        longint unsigned load;
        longint unsigned run;
        int unsigned     num;
    } t_job;

    t_job               p1_list[$];
    t_job               p2_list[$];
    bit                 drop_seen;
    tpsls_pkg::t_result schedule_q[$];
    int                 fail_count;
    int                 idle_cycles;

    function automatic bit job_precedes(t_job a, t_job b);
        if (a.run != b.run) return a.run > b.run;
        if (a.load != b.load) return a.load > b.load;
        return a.num < b.num;
    endfunction

    function automatic void sort_jobs(ref t_job v[$]);
        t_job key;
        int   j;
        for (int i = 1; i < v.size(); i++) begin
            key = v[i];
            j = i;
            while (j > 0 && job_precedes(key, v[j-1])) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = key;
        end
    endfunction

    // Store the task, and on the last one build the whole schedule
    task automatic schedule_task(tpsls_pkg::t_task t);
        t_job               job;
        int                 i1, i2, total, pick;
        logic [1:0]         prev;
        longint unsigned    loader_free, free1, free2, begin_t, fin, longest;
        tpsls_pkg::t_result r;
        job.load = t.load_time;
        job.run  = t.run_time;
        if (t.processor == 1'b0) begin
            if (p1_list.size() < MAX_T) begin
                job.num = p1_list.size() + 1;
                p1_list.insert(p1_list.size(), job);
            end else drop_seen = 1'b1;
        end else begin
            if (p2_list.size() < MAX_T) begin
                job.num = p2_list.size() + 1;
                p2_list.insert(p2_list.size(), job);
            end else drop_seen = 1'b1;
        end
        if (!t.last_task) return;
        sort_jobs(p1_list);
        sort_jobs(p2_list);
        total = p1_list.size() + p2_list.size();
        i1 = 0; i2 = 0; prev = tpsls_pkg::PREV_NONE;
        loader_free = 0; free1 = 0; free2 = 0; longest = 0;
        for (int k = 0; k < total; k++) begin
            if (prev == tpsls_pkg::PREV_P1) pick = (i2 < p2_list.size()) ? 2 : 1;
            else if (prev == tpsls_pkg::PREV_P2) pick = (i1 < p1_list.size()) ? 1 : 2;
            else if (i1 < p1_list.size() && i2 < p2_list.size()) begin
                if (p1_list[i1].run != p2_list[i2].run)
                    pick = (p1_list[i1].run > p2_list[i2].run) ? 1 : 2;
                else if (p1_list[i1].load != p2_list[i2].load)
                    pick = (p1_list[i1].load > p2_list[i2].load) ? 1 : 2;
                else pick = 1;
            end else pick = (i1 < p1_list.size()) ? 1 : 2;
            if (pick == 1) begin
                job = p1_list[i1++];
                begin_t = (loader_free > free1) ? loader_free : free1;
                loader_free = begin_t + job.load;
                fin = loader_free + job.run;
                free1 = fin;
                prev = tpsls_pkg::PREV_P1;
            end else begin
                job = p2_list[i2++];
                begin_t = (loader_free > free2) ? loader_free : free2;
                loader_free = begin_t + job.load;
                fin = loader_free + job.run;
                free2 = fin;
                prev = tpsls_pkg::PREV_P2;
            end
            if (fin > longest) longest = fin;
            r.sched_processor = (pick == 2);
            r.task_number     = job.num[tpsls_pkg::OUT_NUM_W-1:0];
            r.finish_time     = fin[tpsls_pkg::OUT_TIME_W-1:0];
            r.makespan        = longest[tpsls_pkg::OUT_TIME_W-1:0];
            r.overflow        = drop_seen;
            r.last_result     = (k + 1 == total);
            schedule_q.insert(schedule_q.size(), r);
        end
        p1_list.delete();
        p2_list.delete();
        drop_seen = 1'b0;
    endtask

    // Check every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (schedule_q.size() == 0) begin
                $error("result with nothing expected: %p", o_result);
                fail_count++;
            end else begin
                tpsls_pkg::t_result e;
                e = schedule_q.pop_front();
                if (o_result.sched_processor !== e.sched_processor) begin
                    $error("sched_processor exp %0d got %0d",
                           e.sched_processor, o_result.sched_processor);
                    fail_count++;
                end
                if (o_result.task_number !== e.task_number) begin
                    $error("task_number exp %0d got %0d",
                           e.task_number, o_result.task_number);
                    fail_count++;
                end
                if (o_result.finish_time !== e.finish_time) begin
                    $error("finish_time exp %0d got %0d",
                           e.finish_time, o_result.finish_time);
                    fail_count++;
                end
                if (o_result.makespan !== e.makespan) begin
                    $error("makespan exp %0d got %0d", e.makespan, o_result.makespan);
                    fail_count++;
                end
                if (o_result.overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, o_result.overflow);
                    fail_count++;
                end
                if (o_result.last_result !== e.last_result) begin
                    $error("last_result exp %0d got %0d",
                           e.last_result, o_result.last_result);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no transfer happens on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_two_processor_server_load_scheduler_top NOT OK");
            $finish;
        end
    end

    // Drive one transfer from a falling edge: optional gap, raise start,
    // hold until accepted. busy is stable between edges, so its value at
    // the falling edge is the one seen at the next rising edge.
    task automatic send_task(tpsls_pkg::t_task t, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_task <= t;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        schedule_task(t);
        @(negedge i_clk);
    endtask

    function automatic tpsls_pkg::t_task mk_task(bit p, int ld, int rn, bit last);
        tpsls_pkg::t_task t;
        t.processor = p;
        t.load_time = ld[15:0];
        t.run_time  = rn[15:0];
        t.last_task = last;
        return t;
    endfunction

    // Directed table; fixed expectation only for the single-task run
    tpsls_pkg::t_task   dir_tbl[$];
    tpsls_pkg::t_result first_res;

    task automatic add_row(tpsls_pkg::t_task t);
        dir_tbl.insert(dir_tbl.size(), t);
    endtask

    initial begin
        int n_sent, run_len, gap;
        bit no_gaps;
        tpsls_pkg::t_task t;
        fail_count = 0;
        idle_cycles = 0;
        drop_seen = 1'b0;
        start = 1'b0;
        i_task = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Lone task: finish = load + run, everything read at a glance
        add_row(mk_task(0, 65535, 65535, 1));
        // Zero times, tie between the heads, processor 1 wins
        add_row(mk_task(0, 0, 0, 0));
        add_row(mk_task(1, 0, 0, 1));
        // Two equal processor 1 tasks; the longer run on processor 2 puts it first
        add_row(mk_task(0, 3, 10, 0));
        add_row(mk_task(1, 7, 10, 0));
        add_row(mk_task(0, 3, 10, 0));
        add_row(mk_task(1, 1, 65535, 1));
        // Only processor 2 tasks
        add_row(mk_task(1, 5, 2, 0));
        add_row(mk_task(1, 65535, 0, 1));

        first_res = '{sched_processor: 1'b0, task_number: 5'd1,
                      finish_time: 22'd131070, makespan: 22'd131070,
                      overflow: 1'b0, last_result: 1'b1};
        foreach (dir_tbl[i]) begin
            send_task(dir_tbl[i], 0);
            if (i == 0 && (schedule_q.size() != 1 || schedule_q[0] != first_res)) begin
                $error("lone task expectation exp %p got %p", first_res, schedule_q[0]);
                fail_count++;
            end
        end

        // Overflow: 17 processor 1 tasks, 16 for processor 2, near-maximum times
        for (int i = 0; i < 17; i++) send_task(mk_task(0, 65535, 65535 - i, 0), 0);
        for (int i = 0; i < 16; i++) send_task(mk_task(1, 65535 - i, 65535, i == 15), 0);

        // Random runs, mostly small, a few filling the stores
        n_sent = 0;
        while (n_sent < 168) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 36)
                                                  : $urandom_range(1, 8);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < run_len; i++) begin
                t.processor = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0: t.load_time = 16'($urandom_range(0, 3));
                    1: t.load_time = 16'(16'hFFFF - $urandom_range(0, 3));
                    default: t.load_time = 16'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0: t.run_time = 16'($urandom_range(0, 3));
                    1: t.run_time = 16'(16'hFFFF - $urandom_range(0, 3));
                    default: t.run_time = 16'($urandom);
                endcase
                t.last_task = (i == run_len - 1);
                gap = no_gaps ? 0 : $urandom_range(0, 15);
                send_task(t, gap);
                n_sent++;
            end
        end
        start <= 1'b0;

        while (schedule_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("tb_two_processor_server_load_scheduler_top OK");
        else $display("tb_two_processor_server_load_scheduler_top NOT OK");
        $finish;
    end
endmodule

// ===== files.f =====
src/tpsls_pkg.sv
src/tpsls_ram.sv
src/tpsls_pick.sv
src/two_processor_server_load_scheduler_top.sv
tb/tb_two_processor_server_load_scheduler_top.sv
